/* rtl/egb_pkg.sv */
`default_nettype none

package egb_pkg;

  localparam int unsigned DefMaxArms   = 16;
  localparam int unsigned DefValueBits = 16;
  localparam int unsigned DefCountBits = 16;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CfgNumArms   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEpsilon   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLearnRate = 2'd2;

  localparam logic [4:0]  NumArmsRst   = 5'd10;
  localparam logic [16:0] EpsilonRst   = 17'd6554;
  localparam logic [15:0] LearnRateRst = 16'd6554;

  localparam logic ModeSelect = 1'b0;
  localparam logic ModeUpdate = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [15:0]        random_fraction;
    logic [3:0]         random_arm;
    logic [3:0]         arm;
    logic signed [15:0] reward;
  } in_t;

  typedef struct packed {
    logic [3:0]         chosen_arm;
    logic               explored;
    logic [15:0]        arm_count;
    logic signed [15:0] arm_value;
    logic               error;
  } out_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_sweep;
    logic mul;
    logic wr_sel;
    logic wr_upd;
    logic res_err;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic explore;
    logic err;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/epsilon_greedy_bandit_agent_unit.sv */
`default_nettype none

// Epsilon-greedy bandit agent that handles one transaction at a time and
// returns one result per transaction. A select that explores decodes the
// transaction as it is accepted, then reads the arm table, compares, and
// does the write-back that also loads the output register. An update adds
// a multiply step before its write-back. A select that exploits sweeps the
// arm table one entry per cycle through its single read port, over the
// arms in use, compares each entry as it is read, then writes back. An
// update to an arm not in use skips the table and returns an error. A
// result that is still waiting on the output holds the write-back until
// the output register frees, and the next transaction can be accepted in
// the cycle after the write-back. Values and counts read as zero after
// reset without a clearing pass, and configuration writes take effect on the next clock.
module epsilon_greedy_bandit_agent_unit #(
  parameter int unsigned MaxArms   = egb_pkg::DefMaxArms,
  parameter int unsigned ValueBits = egb_pkg::DefValueBits,
  parameter int unsigned CountBits = egb_pkg::DefCountBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [egb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [egb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire egb_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output egb_pkg::out_t                      out_data_o
);

  egb_pkg::cmd_t cmd;
  egb_pkg::sts_t sts;

  egb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  egb_dpath #(
    .MaxArms   (MaxArms),
    .ValueBits (ValueBits),
    .CountBits (CountBits)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* rtl/egb_ctrl.sv */
`default_nettype none

module egb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire egb_pkg::sts_t sts_i,
  output egb_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SWEEP    = 4'd2;
  localparam logic [3:0] S_WAIT     = 4'd3;
  localparam logic [3:0] S_MUL      = 4'd4;
  localparam logic [3:0] S_SEL_WB   = 4'd5;
  localparam logic [3:0] S_UPD_WB   = 4'd6;
  localparam logic [3:0] S_ERR_OUT  = 4'd7;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.mode == egb_pkg::ModeUpdate && sts_i.err) begin
          state_d = S_ERR_OUT;
        end else if (sts_i.mode == egb_pkg::ModeSelect && !sts_i.explore) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_sweep = 1'b1;
          state_d        = sts_i.sweep_last ? S_WAIT : S_SWEEP;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_WAIT;
        end
      end
      S_SWEEP: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = (sts_i.mode == egb_pkg::ModeUpdate) ? S_MUL : S_SEL_WB;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_UPD_WB;
      end
      S_SEL_WB: begin
        if (sts_i.out_free) begin
          cmd_o.wr_sel = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_UPD_WB: begin
        if (sts_i.out_free) begin
          cmd_o.wr_upd = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_ERR_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.res_err = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/egb_dpath.sv */
`default_nettype none

module egb_dpath #(
  parameter int unsigned MaxArms   = egb_pkg::DefMaxArms,
  parameter int unsigned ValueBits = egb_pkg::DefValueBits,
  parameter int unsigned CountBits = egb_pkg::DefCountBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [egb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [egb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire egb_pkg::in_t                  in_data_i,
  input  wire egb_pkg::cmd_t                 cmd_i,
  output egb_pkg::sts_t                      sts_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output egb_pkg::out_t                      out_data_o
);

  localparam int unsigned IdxW  = $clog2(MaxArms);
  localparam int unsigned NaW   = ($clog2(MaxArms + 1) > 5) ? $clog2(MaxArms + 1) : 5;
  localparam int unsigned CmpW  = (IdxW > 4) ? IdxW : 4;
  localparam int unsigned DiffW = ((ValueBits > 16) ? ValueBits : 16) + 1;
  localparam int unsigned ProdW = DiffW + 17;
  localparam int unsigned StepW = ProdW - 16;
  localparam int unsigned SumW  = StepW + 1;
  localparam int unsigned EntW  = CountBits + ValueBits;

  logic [4:0]  num_arms_q;
  logic [16:0] eps_q;
  logic [15:0] lr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_arms_q <= egb_pkg::NumArmsRst;
      eps_q      <= egb_pkg::EpsilonRst;
      lr_q       <= egb_pkg::LearnRateRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        egb_pkg::CfgNumArms:   num_arms_q <= cfg_data_i[4:0];
        egb_pkg::CfgEpsilon:   eps_q      <= cfg_data_i[16:0];
        egb_pkg::CfgLearnRate: lr_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [NaW-1:0]  na_ext;
  logic [IdxW-1:0] last_idx;

  assign na_ext = NaW'(num_arms_q);

  always_comb begin
    if (num_arms_q == '0) begin
      last_idx = '0;
    end else if (na_ext > NaW'(MaxArms)) begin
      last_idx = IdxW'(MaxArms - 1);
    end else begin
      last_idx = IdxW'(na_ext - NaW'(1));
    end
  end

  logic            explore_d, err_d;
  logic [IdxW-1:0] clamp_arm, target_d;

  assign explore_d = ({1'b0, in_data_i.random_fraction} < eps_q);
  assign clamp_arm = (CmpW'(in_data_i.random_arm) > CmpW'(last_idx)) ?
                     last_idx : IdxW'(in_data_i.random_arm);
  assign err_d     = (in_data_i.mode == egb_pkg::ModeUpdate) &&
                     (CmpW'(in_data_i.arm) > CmpW'(last_idx));
  assign target_d  = (in_data_i.mode == egb_pkg::ModeSelect) ? clamp_arm
                                                             : IdxW'(in_data_i.arm);

  logic               mode_q, explore_q, err_q;
  logic [IdxW-1:0]    target_q;
  logic [3:0]         arm_q;
  logic signed [15:0] reward_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= in_data_i.mode;
      explore_q <= explore_d;
      err_q     <= err_d;
      target_q  <= target_d;
      arm_q     <= in_data_i.arm;
      reward_q  <= in_data_i.reward;
    end
  end

  logic [IdxW-1:0] sweep_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else if (cmd_i.load) begin
      sweep_cnt_q <= '0;
    end else if (cmd_i.rd_en && cmd_i.rd_sweep) begin
      sweep_cnt_q <= sweep_cnt_q + IdxW'(1);
    end
  end

  logic [EntW-1:0]    mem [MaxArms];
  logic [MaxArms-1:0] vld_q;
  logic [IdxW-1:0]    rd_addr, cand_idx_q, rd_idx_q;
  logic [EntW-1:0]    rd_ent_q, wr_ent;
  logic               rd_vld_q, cmp_q, first_q, mem_we;

  assign rd_addr = cmd_i.rd_sweep ? sweep_cnt_q : target_q;
  assign mem_we  = cmd_i.wr_sel || cmd_i.wr_upd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_ent_q <= mem[rd_addr];
      rd_vld_q <= vld_q[rd_addr];
      rd_idx_q <= rd_addr;
    end
    if (mem_we) begin
      mem[cand_idx_q] <= wr_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      cmp_q   <= 1'b0;
      first_q <= 1'b0;
    end else begin
      cmp_q   <= cmd_i.rd_en;
      first_q <= cmd_i.rd_en && (!cmd_i.rd_sweep || sweep_cnt_q == '0);
      if (mem_we) begin
        vld_q[cand_idx_q] <= 1'b1;
      end
    end
  end

  logic signed [ValueBits-1:0] rd_val, cand_val_q;
  logic [CountBits-1:0]        rd_cnt, cand_cnt_q;

  assign rd_val = rd_vld_q ? signed'(rd_ent_q[ValueBits-1:0]) : '0;
  assign rd_cnt = rd_vld_q ? rd_ent_q[EntW-1:ValueBits] : '0;

  always_ff @(posedge clk_i) begin
    if (cmp_q && (first_q || rd_val > cand_val_q)) begin
      cand_idx_q <= rd_idx_q;
      cand_val_q <= rd_val;
      cand_cnt_q <= rd_cnt;
    end
  end

  logic signed [DiffW-1:0] diff;
  logic signed [16:0]      lr_s;
  logic signed [ProdW-1:0] prod_d, prod_q;

  assign diff   = DiffW'(reward_q) - DiffW'(cand_val_q);
  assign lr_s   = signed'({1'b0, lr_q});
  assign prod_d = ProdW'(diff) * ProdW'(lr_s);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
  end

  logic signed [StepW-1:0]     step;
  logic signed [SumW-1:0]      sum;
  logic [SumW-ValueBits:0]     sum_hi;
  logic signed [ValueBits-1:0] new_val;
  logic [CountBits-1:0]        cnt_inc;

  assign step   = signed'(prod_q[ProdW-1:16]);
  assign sum    = SumW'(cand_val_q) + SumW'(step);
  assign sum_hi = sum[SumW-1:ValueBits-1];

  always_comb begin
    if (sum_hi == '0 || sum_hi == '1) begin
      new_val = sum[ValueBits-1:0];
    end else if (sum[SumW-1]) begin
      new_val = {1'b1, {(ValueBits-1){1'b0}}};
    end else begin
      new_val = {1'b0, {(ValueBits-1){1'b1}}};
    end
  end

  assign cnt_inc = (&cand_cnt_q) ? cand_cnt_q : cand_cnt_q + CountBits'(1);
  assign wr_ent  = cmd_i.wr_sel ? {cnt_inc, cand_val_q} : {cand_cnt_q, new_val};

  egb_pkg::out_t out_d, out_q;
  logic          out_valid_q, res_load;

  assign res_load = cmd_i.wr_sel || cmd_i.wr_upd || cmd_i.res_err;

  always_comb begin
    out_d = '0;
    if (cmd_i.wr_sel) begin
      out_d.chosen_arm = 4'(cand_idx_q);
      out_d.explored   = explore_q;
      out_d.arm_count  = 16'(cnt_inc);
      out_d.arm_value  = 16'(cand_val_q);
    end else if (cmd_i.wr_upd) begin
      out_d.chosen_arm = arm_q;
      out_d.arm_count  = 16'(cand_cnt_q);
      out_d.arm_value  = 16'(new_val);
    end else begin
      out_d.chosen_arm = arm_q;
      out_d.error      = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !out_ready_i) || res_load;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.mode       = mode_q;
  assign sts_o.explore    = explore_q;
  assign sts_o.err        = err_q;
  assign sts_o.sweep_last = (sweep_cnt_q == last_idx);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire
